/* hw/rtl/sfse_pkg.sv */
`timescale 1ns / 1ps

package sfse_pkg;

  // Line geometry and magnitude width
  localparam int unsigned MAX_LINE = 4096;
  localparam int unsigned MAG_BITS = 16;

  // Field widths
  localparam int unsigned POS_W   = 12;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned COUNT_W = $clog2(MAX_LINE + 1);
  localparam int unsigned SUM_W   = $clog2(MAX_LINE * ((64'd1 << MAG_BITS) - 1) + 1);
  localparam int unsigned LHS_W   = MAG_BITS + COUNT_W + 8;
  localparam int unsigned RHS_W   = CFG_W + SUM_W;

  // Saturation limits
  localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_LINE);
  localparam logic [SUM_W-1:0]   SUM_MAX   =
    SUM_W'(MAX_LINE * ((64'd1 << MAG_BITS) - 1));

  // Register map (index taken from paddr[2])
  localparam logic REG_MAG_THRESHOLD = 1'b0;
  localparam logic REG_LAMBDA_Q8     = 1'b1;

  localparam logic [CFG_W-1:0] THRESHOLD_RESET = '0;
  localparam logic [CFG_W-1:0] LAMBDA_RESET    = CFG_W'(256);

  // One pixel beat as held in the input register
  typedef struct packed {
    logic [MAG_BITS-1:0] magnitude;
    logic                in_mask;
    logic                excluded;
    logic                line_start;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
  } pixel_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [CFG_W-1:0] mag_threshold;
    logic [CFG_W-1:0] lambda_q8;
  } cfg_t;

endpackage

/* hw/rtl/sfse_cfg_regs.sv */
`timescale 1ns / 1ps

module sfse_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output sfse_pkg::cfg_t      cfg
);

  logic [sfse_pkg::CFG_W-1:0] mag_threshold;
  logic [sfse_pkg::CFG_W-1:0] lambda_q8;
  logic                       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Register writes complete in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      mag_threshold <= sfse_pkg::THRESHOLD_RESET;
      lambda_q8     <= sfse_pkg::LAMBDA_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        sfse_pkg::REG_MAG_THRESHOLD: mag_threshold <= pwdata[sfse_pkg::CFG_W-1:0];
        sfse_pkg::REG_LAMBDA_Q8:     lambda_q8     <= pwdata[sfse_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (paddr[2])
      sfse_pkg::REG_MAG_THRESHOLD: prdata = 32'(mag_threshold);
      sfse_pkg::REG_LAMBDA_Q8:     prdata = 32'(lambda_q8);
      default:                     prdata = '0;
    endcase
  end

  assign cfg.mag_threshold = mag_threshold;
  assign cfg.lambda_q8     = lambda_q8;

endmodule

/* hw/rtl/sfse_core.sv */
`timescale 1ns / 1ps

module sfse_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  sfse_pkg::pixel_t pixel,
  input  sfse_pkg::cfg_t   cfg,
  output logic             hit
);

  logic [sfse_pkg::SUM_W-1:0]   running_sum;
  logic [sfse_pkg::COUNT_W-1:0] used_count;
  logic                         line_done;

  logic [sfse_pkg::SUM_W-1:0]   running_sum_next;
  logic [sfse_pkg::COUNT_W-1:0] used_count_next;
  logic                         line_done_next;

  logic [sfse_pkg::SUM_W-1:0]   sum_cur;
  logic [sfse_pkg::COUNT_W-1:0] count_cur;
  logic                         done_cur;
  logic                         used;
  logic [sfse_pkg::MAG_BITS+sfse_pkg::COUNT_W-1:0] mag_count;
  logic [sfse_pkg::LHS_W-1:0]   lhs;
  logic [sfse_pkg::RHS_W-1:0]   rhs;
  logic                         strong_px;
  logic [sfse_pkg::SUM_W:0]     sum_add;

  // A line start clears the line state before the pixel is looked at.
  assign sum_cur   = pixel.line_start ? '0   : running_sum;
  assign count_cur = pixel.line_start ? '0   : used_count;
  assign done_cur  = pixel.line_start ? 1'b0 : line_done;
  assign used      = pixel.in_mask && !pixel.excluded;

  // Compare magnitude * count * 256 against lambda * sum.
  assign mag_count = (sfse_pkg::MAG_BITS + sfse_pkg::COUNT_W)'(pixel.magnitude) *
                     (sfse_pkg::MAG_BITS + sfse_pkg::COUNT_W)'(count_cur);
  assign lhs = {mag_count, 8'b0};
  assign rhs = sfse_pkg::RHS_W'(cfg.lambda_q8) * sfse_pkg::RHS_W'(sum_cur);
  assign strong_px = (pixel.magnitude > sfse_pkg::MAG_BITS'(cfg.mag_threshold)) &&
                     (sfse_pkg::RHS_W'(lhs) >= rhs);

  assign hit = used && !done_cur && (count_cur != '0) && strong_px;

  // Saturating accumulation of non-hit used pixels.
  assign sum_add = {1'b0, sum_cur} + (sfse_pkg::SUM_W + 1)'(pixel.magnitude);

  always_comb begin
    running_sum_next = sum_cur;
    used_count_next  = count_cur;
    line_done_next   = done_cur;
    if (hit) begin
      line_done_next = 1'b1;
    end else if (used && !done_cur) begin
      running_sum_next = (sum_add > (sfse_pkg::SUM_W + 1)'(sfse_pkg::SUM_MAX)) ?
                         sfse_pkg::SUM_MAX : sum_add[sfse_pkg::SUM_W-1:0];
      if (count_cur < sfse_pkg::COUNT_MAX) begin
        used_count_next = count_cur + sfse_pkg::COUNT_W'(1);
      end
    end
  end

  // Line state moves only when the pixel leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      used_count  <= '0;
      line_done   <= 1'b0;
    end else if (advance) begin
      running_sum <= running_sum_next;
      used_count  <= used_count_next;
      line_done   <= line_done_next;
    end
  end

endmodule

/* hw/rtl/scanline_first_strong_edge_unit.sv */
`timescale 1ns / 1ps

// First strong edge finder for one scan line at a time.
// Pixels enter on the s_axis channel, one beat per pixel in scan order; a
// beat with line_start set opens a new line and clears the running sum,
// count and hit flag. Used pixels (in mask, not excluded) are summed; the
// first used pixel after another that exceeds the threshold and reaches
// lambda times the running mean gives one beat on m_axis with its x and y,
// and the rest of the line is then ignored.
// A pixel beat is evaluated from the input register and its result beat is
// presented from the result register. Throughput: one pixel per cycle; the
// loop through the line state is one pass of two parallel multipliers, a
// compare and a saturating add. When the result receiver stalls, pixels
// that give no hit keep flowing; only a second hit waits, and s_axis_tready
// falls until the output frees. Reset clears the line state and the
// pipeline, and loads the registers with threshold 0 and lambda 1.0 (256).
// Registers are written through the APB port at byte addresses 0 and 4;
// the user must do so only while the block is idle; it is not enforced.

module scanline_first_strong_edge_unit (
  input  logic        clk,
  input  logic        rst,
  // tdata: magnitude[15:0], pos_x[27:16], pos_y[39:28]
  input  logic [39:0] s_axis_tdata,
  // tuser: in_mask[0], excluded[1], line_start[2]
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: hit_x[11:0], hit_y[23:12]
  output logic [23:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  sfse_pkg::cfg_t   cfg;
  sfse_pkg::pixel_t pixel;
  logic             pix_valid;
  logic             hit;
  logic             advance;
  logic [23:0]      out_data;
  logic             out_valid;

  sfse_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The held pixel leaves unless it hits while the output is full and stalled.
  assign advance       = pix_valid && (!hit || !out_valid || m_axis_tready);
  assign s_axis_tready = !pix_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (s_axis_tready) begin
      pix_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      pixel.magnitude  <= s_axis_tdata[15:0];
      pixel.pos_x      <= s_axis_tdata[27:16];
      pixel.pos_y      <= s_axis_tdata[39:28];
      pixel.in_mask    <= s_axis_tuser[0];
      pixel.excluded   <= s_axis_tuser[1];
      pixel.line_start <= s_axis_tuser[2];
    end
  end

  sfse_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .pixel   (pixel),
    .cfg     (cfg),
    .hit     (hit)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && hit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && hit) begin
      out_data <= {pixel.pos_y, pixel.pos_x};
    end
  end

  assign m_axis_tdata  = out_data;
  assign m_axis_tvalid = out_valid;

endmodule
